[rtl/sld_pkg.sv]
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the sync/length frame deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

    // Frame header bytes and the token that follows the length byte
    localparam logic [7:0] SYNC_0     = 8'h55;
    localparam logic [7:0] SYNC_1     = 8'h4E;
    localparam logic [7:0] SYNC_2     = 8'h45;
    localparam logic [7:0] SYNC_3     = 8'h52;
    localparam logic [7:0] TOKEN_CHAR = 8'h3A;

    // Checksum seed: header, token (length byte is folded in separately)
    localparam logic [7:0] CSUM_SEED  = SYNC_0 ^ SYNC_1 ^ SYNC_2 ^ SYNC_3 ^ TOKEN_CHAR;

    // Idle timeout register value after reset
    localparam logic [7:0] IDLE_TIMEOUT_RESET = 8'd6;

    // Input action codes
    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_FRAME_OK  = 2'd1,
        KIND_FRAME_BAD = 2'd2
    } kind_t;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC_N  = 3'd1,
        PH_SYNC_E  = 3'd2,
        PH_SYNC_R  = 3'd3,
        PH_LENGTH  = 3'd4,
        PH_TOKEN   = 3'd5,
        PH_PAYLOAD = 3'd6
    } phase_t;

    // One result from the parser toward the output stage
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] position;
        logic [7:0] frame_length;
        logic [7:0] computed_checksum;
    } result_t;

endpackage

[rtl/sync_length_frame_deframer.sv]
// ----------------------------------------------------------------------------
// sync_length_frame_deframer
// Deframer for sync/length/token frames with an XOR checksum and idle timer.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock, a received byte or a timer tick,
// and gives at most one result per transaction in the next cycle through a
// single result register; the input stays ready while that register is empty
// or being drained, so throughput is one transaction per cycle. Each payload
// byte comes out as it arrives; the checksum byte closes the frame with a
// good/bad result. The idle timeout register is reloaded into the idle timer
// by every byte and is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while the block is idle, which the block does not enforce.
module sync_length_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,  // idle_timeout_ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] rx_byte
    input  logic [0:0]  s_tuser,      // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // [7:0] data, [15:8] position,
                                      // [23:16] frame_length, [31:24] computed_checksum
    output logic [1:0]  m_tuser       // [1:0] kind
);

    sld_pkg::result_t result;
    logic             in_ready;
    logic             accept;

    assign s_tready = in_ready;
    assign accept   = s_tvalid && in_ready;

    // Parser
    sld_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .action      (s_tuser[0]),
        .rx_byte     (s_tdata),
        .result      (result)
    );

    // Result register
    sld_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .in_ready (in_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/sld_parser.sv]
// ----------------------------------------------------------------------------
// sld_parser
// Frame parser state, idle timer and timeout register; one transaction per
// cycle while accept is high; result produced combinationally for the output register.
// ----------------------------------------------------------------------------
module sld_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                accept,
    input  logic                action,
    input  logic [7:0]          rx_byte,
    output sld_pkg::result_t    result
);

    sld_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      timeout_reg;
    logic [7:0]      bytes_left_reg, bytes_left_next;
    logic [7:0]      frame_len_reg, frame_len_next;
    logic [7:0]      csum_reg, csum_next;
    logic [7:0]      index_reg, index_next;
    logic [7:0]      idle_reg, idle_next;
    sld_pkg::phase_t hunt_phase;
    logic            more_payload;
    logic [7:0]      csum_payload;
    logic [7:0]      index_inc;

    // Byte seen as a possible first sync byte
    assign hunt_phase   = (rx_byte == sld_pkg::SYNC_0) ? sld_pkg::PH_SYNC_N
                                                        : sld_pkg::PH_HUNT;
    assign more_payload = (bytes_left_reg > 8'd1);
    assign csum_payload = csum_reg ^ rx_byte;
    assign index_inc    = index_reg + 8'd1;

    // Next state
    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        frame_len_next  = frame_len_reg;
        csum_next       = csum_reg;
        index_next      = index_reg;
        idle_next       = idle_reg;
        if (accept)
        begin
            if (action == sld_pkg::ACTION_TICK)
            begin
                if (idle_reg != 8'd0)
                begin
                    idle_next = idle_reg - 8'd1;
                    if (idle_reg == 8'd1)
                    begin
                        phase_next = sld_pkg::PH_HUNT;
                    end
                end
            end
            else
            begin
                idle_next = timeout_reg;
                case (phase_reg)
                    sld_pkg::PH_HUNT:
                    begin
                        phase_next = hunt_phase;
                    end
                    sld_pkg::PH_SYNC_N:
                    begin
                        phase_next = (rx_byte == sld_pkg::SYNC_1) ? sld_pkg::PH_SYNC_E
                                                                  : hunt_phase;
                    end
                    sld_pkg::PH_SYNC_E:
                    begin
                        phase_next = (rx_byte == sld_pkg::SYNC_2) ? sld_pkg::PH_SYNC_R
                                                                  : hunt_phase;
                    end
                    sld_pkg::PH_SYNC_R:
                    begin
                        phase_next = (rx_byte == sld_pkg::SYNC_3) ? sld_pkg::PH_LENGTH
                                                                  : hunt_phase;
                    end
                    sld_pkg::PH_LENGTH:
                    begin
                        frame_len_next  = rx_byte;
                        bytes_left_next = rx_byte;
                        // zero length aborts the frame
                        phase_next = (rx_byte == 8'd0) ? sld_pkg::PH_HUNT
                                                       : sld_pkg::PH_TOKEN;
                    end
                    sld_pkg::PH_TOKEN:
                    begin
                        if (rx_byte == sld_pkg::TOKEN_CHAR)
                        begin
                            csum_next  = sld_pkg::CSUM_SEED ^ frame_len_reg;
                            index_next = 8'd0;
                            phase_next = sld_pkg::PH_PAYLOAD;
                        end
                        else
                        begin
                            phase_next = hunt_phase;
                        end
                    end
                    sld_pkg::PH_PAYLOAD:
                    begin
                        if (more_payload)
                        begin
                            csum_next       = csum_payload;
                            index_next      = index_inc;
                            bytes_left_next = bytes_left_reg - 8'd1;
                        end
                        else
                        begin
                            bytes_left_next = 8'd0;
                            phase_next      = sld_pkg::PH_HUNT;
                        end
                    end
                    default:
                    begin
                        phase_next = sld_pkg::PH_HUNT;
                    end
                endcase
            end
        end
    end

    // Result for this transaction
    always_comb
    begin
        result.valid             = 1'b0;
        result.kind              = sld_pkg::KIND_PAYLOAD;
        result.data              = rx_byte;
        result.position          = index_inc;
        result.frame_length      = frame_len_reg;
        result.computed_checksum = csum_payload;
        if (accept && (action == sld_pkg::ACTION_BYTE) &&
            (phase_reg == sld_pkg::PH_PAYLOAD))
        begin
            result.valid = 1'b1;
            if (!more_payload)
            begin
                // checksum byte closes the frame
                result.kind              = (csum_reg == rx_byte) ? sld_pkg::KIND_FRAME_OK
                                                                 : sld_pkg::KIND_FRAME_BAD;
                result.position          = index_reg;
                result.computed_checksum = csum_reg;
            end
        end
    end

    // State and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= sld_pkg::PH_HUNT;
            timeout_reg    <= sld_pkg::IDLE_TIMEOUT_RESET;
            bytes_left_reg <= 8'd0;
            frame_len_reg  <= 8'd0;
            csum_reg       <= 8'd0;
            index_reg      <= 8'd0;
            idle_reg       <= 8'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            frame_len_reg  <= frame_len_next;
            csum_reg       <= csum_next;
            index_reg      <= index_next;
            idle_reg       <= idle_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

endmodule

[rtl/sld_out_reg.sv]
// ----------------------------------------------------------------------------
// sld_out_reg
// Result register on the master side; takes a new result when empty or while
// the held one leaves, so the input side then keeps one transaction per cycle.
// ----------------------------------------------------------------------------
module sld_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  sld_pkg::result_t    result,
    output logic                in_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,
    output logic [1:0]          m_tuser
);

    logic             valid_reg;
    sld_pkg::result_t hold_reg;

    // Room for a result when empty or when the held one leaves this cycle
    assign in_ready = !valid_reg || m_tready;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= result.valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_ready && result.valid)
        begin
            hold_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = hold_reg.kind;
    assign m_tdata  = {hold_reg.computed_checksum, hold_reg.frame_length,
                       hold_reg.position, hold_reg.data};

endmodule

[rtl/sld_checker.sv]
// ----------------------------------------------------------------------------
// sld_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sld_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Stalled result holds its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Input back-pressure only while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

    // A tick never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == sld_pkg::ACTION_TICK) |=> !m_tvalid)
        else $error("result after a tick");

    // Kind is a defined code, and payload positions start at one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == sld_pkg::KIND_PAYLOAD && m_tdata[15:8] != 8'd0) ||
                     m_tuser == sld_pkg::KIND_FRAME_OK ||
                     m_tuser == sld_pkg::KIND_FRAME_BAD)
        else $error("bad result kind or position");

endmodule

bind sync_length_frame_deframer sld_checker u_sld_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sync/length frame deframer. A short table of
// hand-made frames comes first: a one-byte frame, a repeated sync byte, a
// zero length, a token replaced by a sync byte and a bad checksum. Random
// traffic follows under four idle timeout settings. Every transaction that
// enters the block is run through a local deframer model, and each result
// that leaves it is checked against the oldest expected result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction at all
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 60;    // long output stall

    // One expected result, laid out like the output fields
    typedef struct packed {
        sld_pkg::kind_t kind;
        logic [7:0]     data;
        logic [7:0]     position;
        logic [7:0]     frame_length;
        logic [7:0]     computed_checksum;
    } deframed_t;

    // One input transaction; typed rows carry a hand-written result
    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
        logic       typed;
        deframed_t  typed_res;
    } rx_item_t;

    localparam deframed_t NO_TYPED = '0;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'd0;  // [7:0] rx_byte
    logic [0:0]  s_tuser     = 1'b0;  // [0] action
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;             // [7:0] data, [15:8] position,
                                      // [23:16] frame_length, [31:24] computed_checksum
    logic [1:0]  m_tuser;             // [1:0] kind

    // Model of the parser
    logic [7:0]      timeout_cfg = sld_pkg::IDLE_TIMEOUT_RESET;
    sld_pkg::phase_t frm_phase   = sld_pkg::PH_HUNT;
    logic [7:0]      frm_left    = 8'd0;
    logic [7:0]      frm_len     = 8'd0;
    logic [7:0]      frm_csum    = 8'd0;
    logic [7:0]      frm_index   = 8'd0;
    logic [7:0]      idle_ticks  = 8'd0;

    deframed_t deframed_q [$];
    rx_item_t  stim_q [$];
    logic [7:0] sync_bytes [4] = '{sld_pkg::SYNC_0, sld_pkg::SYNC_1,
                                   sld_pkg::SYNC_2, sld_pkg::SYNC_3};

    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    bit stall_req    = 1'b0;
    int gen_bytes;
    int fault_count  = 0;
    int n_bytes      = 0;
    int n_ticks      = 0;
    int n_payload    = 0;
    int n_good       = 0;
    int n_bad        = 0;
    int n_timeouts   = 0;

    // Directed frames: {action, byte, typed, expected result}
    rx_item_t directed_rows [0:26] = '{
        // tick while the idle timer is already zero
        '{sld_pkg::ACTION_TICK, 8'h00, 1'b0, NO_TYPED},
        // frame of length one: no payload, only the checksum
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_0, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_1, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_2, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_3, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, 8'h01, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::TOKEN_CHAR, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, 8'h37, 1'b1,
          '{sld_pkg::KIND_FRAME_OK, 8'h37, 8'd0, 8'd1, 8'h37}},
        // repeated first sync byte is taken again, then zero length aborts
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_0, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_0, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_1, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_2, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_3, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, 8'h00, 1'b0, NO_TYPED},
        // sync byte in place of the token starts a new header
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_0, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_1, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_2, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_3, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, 8'h03, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_0, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_1, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_2, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::SYNC_3, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, 8'h02, 1'b0, NO_TYPED},
        '{sld_pkg::ACTION_BYTE, sld_pkg::TOKEN_CHAR, 1'b0, NO_TYPED},
        // all-ones payload, then a wrong all-zeros checksum
        '{sld_pkg::ACTION_BYTE, 8'hFF, 1'b1,
          '{sld_pkg::KIND_PAYLOAD, 8'hFF, 8'd1, 8'd2, 8'hCB}},
        '{sld_pkg::ACTION_BYTE, 8'h00, 1'b1,
          '{sld_pkg::KIND_FRAME_BAD, 8'h00, 8'd1, 8'd2, 8'hCB}}
    };

    sync_length_frame_deframer u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Header/token match, or fall back to hunting with the same byte
    function automatic sld_pkg::phase_t resync(input logic [7:0] b, input logic [7:0] want,
                                               input sld_pkg::phase_t nxt);
        if (b == want)
            return nxt;
        if (b == sld_pkg::SYNC_0)
            return sld_pkg::PH_SYNC_N;
        return sld_pkg::PH_HUNT;
    endfunction

    // Advance the parser model by one transaction; returns 1 with a result
    function automatic bit deframe_step(input logic action, input logic [7:0] b,
                                        output deframed_t res);
        res = '0;
        if (action == sld_pkg::ACTION_TICK)
        begin
            if (idle_ticks != 8'd0)
            begin
                idle_ticks = idle_ticks - 8'd1;
                if (idle_ticks == 8'd0)
                begin
                    frm_phase = sld_pkg::PH_HUNT;
                    n_timeouts++;
                end
            end
            return 1'b0;
        end
        idle_ticks = timeout_cfg;
        case (frm_phase)
            sld_pkg::PH_HUNT:
                frm_phase = resync(b, sld_pkg::SYNC_0, sld_pkg::PH_SYNC_N);
            sld_pkg::PH_SYNC_N:
                frm_phase = resync(b, sld_pkg::SYNC_1, sld_pkg::PH_SYNC_E);
            sld_pkg::PH_SYNC_E:
                frm_phase = resync(b, sld_pkg::SYNC_2, sld_pkg::PH_SYNC_R);
            sld_pkg::PH_SYNC_R:
                frm_phase = resync(b, sld_pkg::SYNC_3, sld_pkg::PH_LENGTH);
            sld_pkg::PH_LENGTH:
            begin
                frm_len  = b;
                frm_left = b;
                if (b == 8'd0)
                    frm_phase = sld_pkg::PH_HUNT;
                else
                    frm_phase = sld_pkg::PH_TOKEN;
            end
            sld_pkg::PH_TOKEN:
            begin
                if (b == sld_pkg::TOKEN_CHAR)
                begin
                    frm_csum  = sld_pkg::CSUM_SEED ^ frm_len;
                    frm_index = 8'd0;
                end
                frm_phase = resync(b, sld_pkg::TOKEN_CHAR, sld_pkg::PH_PAYLOAD);
            end
            sld_pkg::PH_PAYLOAD:
            begin
                if (frm_left > 8'd1)
                begin
                    frm_csum  = frm_csum ^ b;
                    frm_index = frm_index + 8'd1;
                    frm_left  = frm_left - 8'd1;
                    res = '{sld_pkg::KIND_PAYLOAD, b, frm_index, frm_len, frm_csum};
                    n_payload++;
                    return 1'b1;
                end
                frm_left  = 8'd0;
                frm_phase = sld_pkg::PH_HUNT;
                res = '{sld_pkg::KIND_FRAME_OK, b, frm_index, frm_len, frm_csum};
                if (frm_csum != b)
                begin
                    res.kind = sld_pkg::KIND_FRAME_BAD;
                    n_bad++;
                end
                else
                    n_good++;
                return 1'b1;
            end
            default:   frm_phase = sld_pkg::PH_HUNT;
        endcase
        return 1'b0;
    endfunction

    // Stimulus building
    task automatic queue_ticks(input int count);
        repeat (count)
            stim_q.push_back(rx_item_t'{sld_pkg::ACTION_TICK, 8'($urandom), 1'b0, NO_TYPED});
    endtask

    task automatic queue_byte(input logic [7:0] b);
        // an occasional stray tick between bytes
        if ($urandom_range(99) < 5)
            queue_ticks(1);
        stim_q.push_back(rx_item_t'{sld_pkg::ACTION_BYTE, b, 1'b0, NO_TYPED});
        gen_bytes++;
    endtask

    task automatic queue_random_traffic(input int target, input bit lead_long);
        int         pick;
        int         cut;
        int         keep;
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        gen_bytes = 0;
        while (gen_bytes < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70 || lead_long)
            begin
                // well-formed frame, sometimes cut short or with a bad checksum
                if (lead_long)
                    len = 8'd255;
                else if ($urandom_range(99) < 3)
                    len = 8'($urandom_range(200, 255));
                else
                    len = 8'($urandom_range(1, 12));
                lead_long = 1'b0;
                sum = sld_pkg::CSUM_SEED ^ len;
                foreach (sync_bytes[i])
                    queue_byte(sync_bytes[i]);
                queue_byte(len);
                queue_byte(sld_pkg::TOKEN_CHAR);
                cut = ($urandom_range(99) < 8) ? $urandom_range(0, int'(len) - 1) : int'(len);
                for (int i = 1; i < cut; i++)
                begin
                    b = 8'($urandom);
                    sum = sum ^ b;
                    queue_byte(b);
                end
                if (cut == int'(len))
                    queue_byte(($urandom_range(99) < 85) ? sum : 8'($urandom));
                if (cut != int'(len) || $urandom_range(99) < 10)
                    queue_ticks($urandom_range(1, 10));
            end
            else if (pick < 85)
            begin
                // broken header: partial sync, then a wrong byte or zero length
                keep = $urandom_range(1, 5);
                for (int i = 0; i < keep && i < 4; i++)
                    queue_byte(sync_bytes[i]);
                if (keep == 5)
                    queue_byte(8'd0);
                else
                    queue_byte(8'($urandom));
            end
            else
            begin
                // line noise
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(1) == 0)
                        queue_ticks(1);
                    else
                        queue_byte(8'($urandom));
                end
            end
        end
    endtask

    // Send the queued transactions and record what each one should produce
    task automatic drive_stimulus();
        rx_item_t  it;
        deframed_t res;
        bit        has_res;
        while (stim_q.size() != 0)
        begin
            it = stim_q.pop_front();
            while ($urandom_range(99) < send_gap_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= it.action;
            s_tdata  <= it.rx_byte;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            if (it.action == sld_pkg::ACTION_TICK)
                n_ticks++;
            else
                n_bytes++;
            has_res = deframe_step(it.action, it.rx_byte, res);
            if (it.typed)
                deframed_q.push_back(it.typed_res);
            else if (has_res)
                deframed_q.push_back(res);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Register write once the block has gone quiet
    task automatic write_timeout(input logic [7:0] ticks);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        timeout_cfg = ticks;
    endtask

    // Output side: random back-pressure plus one long hold on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Result checker
    initial
    begin
        deframed_t want;
        deframed_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = '{sld_pkg::kind_t'(m_tuser), m_tdata[7:0], m_tdata[15:8],
                        m_tdata[23:16], m_tdata[31:24]};
                if (deframed_q.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected result: kind %0d data %h pos %0d len %0d csum %h",
                                 got.kind, got.data, got.position, got.frame_length,
                                 got.computed_checksum);
                    fault_count++;
                end
                else
                begin
                    want = deframed_q.pop_front();
                    if (got !== want)
                    begin
                        if (fault_count < 10)
                            $display({"mismatch: got kind %0d data %h pos %0d len %0d csum %h,",
                                      " expected kind %0d data %h pos %0d len %0d csum %h"},
                                     got.kind, got.data, got.position, got.frame_length,
                                     got.computed_checksum, want.kind, want.data,
                                     want.position, want.frame_length,
                                     want.computed_checksum);
                        fault_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too long with no transaction on either side
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("testbench: errors");
        $finish;
    end

    // Main sequence
    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timeout, input idles less than output
        send_gap_pct = 33;
        recv_gap_pct = 53;
        foreach (directed_rows[i])
            stim_q.push_back(directed_rows[i]);
        queue_random_traffic(90, 1'b0);
        drive_stimulus();

        // idle timer disabled, output idles less than input
        write_timeout(8'd0);
        send_gap_pct = 53;
        recv_gap_pct = 33;
        queue_random_traffic(100, 1'b0);
        drive_stimulus();

        // longest timeout, full rate, a maximum-length frame
        write_timeout(8'd255);
        send_gap_pct = 0;
        recv_gap_pct = 0;
        queue_random_traffic(200, 1'b1);
        drive_stimulus();

        // short timeout, with a long output stall while input keeps coming
        write_timeout(8'd2);
        stall_req = 1'b1;
        queue_random_traffic(100, 1'b0);
        drive_stimulus();

        drain_results();
        fault_count += deframed_q.size();
        $display("Covered %0d bytes and %0d ticks, %0d idle timeouts, timeouts 6/0/255/2",
                 n_bytes, n_ticks, n_timeouts);
        $display("Checked %0d payload bytes, %0d good and %0d bad frames, %0d faults",
                 n_payload, n_good, n_bad, fault_count);
        if (fault_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
